### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for clocked concurrent assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

### src/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// types, opcodes and the command length table of the sound command framer
// ----------------------------------------------------------------------------
package scf_pkg;

  typedef enum logic [2:0] {
    ACT_OTHER      = 3'd0,
    ACT_BGM_START  = 3'd1,
    ACT_BGM_STOP   = 3'd2,
    ACT_MUSIC_SUM  = 3'd3,
    ACT_EFFECT_SUM = 3'd4,
    ACT_STOP_ALL   = 3'd5
  } action_e;

  localparam logic [7:0] OP_END        = 8'hFF;
  localparam logic [7:0] OP_STOP_ALL   = 8'h10;
  localparam logic [7:0] OP_BGM_START  = 8'h20;
  localparam logic [7:0] OP_BGM_STOP   = 8'h21;
  localparam logic [7:0] OP_MUSIC_SUM  = 8'h28;
  localparam logic [7:0] OP_EFFECT_SUM = 8'h29;

  localparam logic [3:0] MUSIC_PORTS  = 4'd4;
  localparam logic [3:0] EFFECT_PORTS = 4'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
  } cmd_beat_t;

  typedef struct packed {
    action_e     action;
    logic [7:0]  cmd_code;
    logic [3:0]  port_number;
    logic [15:0] bgm_mask;
  } res_beat_t;

  // command length in bytes, zero when the opcode is undefined
  function automatic logic [3:0] frame_len(input logic [7:0] op);
    logic [3:0] n;
    n = 4'd0;
    case (op[7:4])
      4'h0: n = 4'd4 + {3'd0, op[0]} + {3'd0, op[1]} + {2'd0, op[2], 1'b0};
      4'h1: n = (op == 8'h11) ? 4'd3 : 4'd1;
      4'h2: begin
        case (op) inside
          [8'h22:8'h25]:                        n = 4'd3;
          8'h26:                                n = 4'd4;
          8'h20:                                n = 4'd5;
          8'h27, 8'h28, 8'h29, 8'h2C, 8'h2D:    n = 4'd8;
          default:                              n = 4'd2;
        endcase
      end
      4'h4: begin
        case (op) inside
          8'h41, 8'h42, [8'h47:8'h4A]:          n = 4'd2;
          8'h4B, 8'h4D, 8'h4E:                  n = 4'd3;
          8'h45, 8'h4C:                         n = 4'd4;
          8'h44, 8'h4F:                         n = 4'd6;
          default:                              n = 4'd1;
        endcase
      end
      4'h5, 4'h6: n = (op inside {[8'h51:8'h54]}) ? 4'd8 : 4'd2;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

### src/scf_cmd_if.sv
// ----------------------------------------------------------------------------
// scf_cmd_if
// command byte channel, one buffer byte per beat
// ----------------------------------------------------------------------------
interface scf_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_start;

  modport source (output valid, output data_byte, output buffer_start, input ready);
  modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

### src/scf_res_if.sv
// ----------------------------------------------------------------------------
// scf_res_if
// result channel, one completed command per beat
// ----------------------------------------------------------------------------
interface scf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  cmd_code;
  logic [3:0]  port_number;
  logic [15:0] bgm_mask;

  modport source (output valid, output action, output cmd_code, output port_number,
                  output bgm_mask, input ready);
  modport sink   (input valid, input action, input cmd_code, input port_number,
                  input bgm_mask, output ready);
endinterface

### src/sound_command_stream_framer.sv
// ----------------------------------------------------------------------------
// sound_command_stream_framer
// frames sound driver command buffers and reports each completed command
// ----------------------------------------------------------------------------
// Takes one command buffer byte per beat and sustains one byte per cycle while
// result beats are taken. A completed command shows on the result channel once
// its last byte has passed the input register and then the result register. The
// result register loads as the parser takes the byte, and the framing state
// and port mask update at that same edge. Bytes that only extend a command,
// end markers, undefined opcodes and bytes seen while halted produce no beat.
// While a result beat waits untaken, the parser holds. The input register
// takes one more byte, and then ready stays low until the result is taken.
module sound_command_stream_framer import scf_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  scf_cmd_if.sink   cmd_i,
  scf_res_if.source res_o
);

  cmd_beat_t in_beat;
  cmd_beat_t reg_beat;
  logic      reg_vld;
  logic      reg_take;
  res_beat_t res_beat;

  assign in_beat = '{data_byte: cmd_i.data_byte, buffer_start: cmd_i.buffer_start};

  scf_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (cmd_i.valid),
    .rdy_o  (cmd_i.ready),
    .beat_i (in_beat),
    .vld_o  (reg_vld),
    .take_i (reg_take),
    .beat_o (reg_beat)
  );

  scf_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_vld_i  (reg_vld),
    .beat_i      (reg_beat),
    .beat_take_o (reg_take),
    .res_vld_o   (res_o.valid),
    .res_rdy_i   (res_o.ready),
    .res_o       (res_beat)
  );

  assign res_o.action      = res_beat.action;
  assign res_o.cmd_code    = res_beat.cmd_code;
  assign res_o.port_number = res_beat.port_number;
  assign res_o.bgm_mask    = res_beat.bgm_mask;

endmodule

### src/scf_in_reg.sv
// ----------------------------------------------------------------------------
// scf_in_reg
// input register stage, holds one command byte beat until the parser takes it
// ----------------------------------------------------------------------------
module scf_in_reg import scf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  output logic      rdy_o,
  input  cmd_beat_t beat_i,
  output logic      vld_o,
  input  logic      take_i,
  output cmd_beat_t beat_o
);

  logic      vld_q, vld_d;
  cmd_beat_t beat_q;

  assign rdy_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (rdy_o) begin
      vld_d = vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      beat_q <= beat_i;
    end
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;

endmodule

### src/scf_parse.sv
// ----------------------------------------------------------------------------
// scf_parse
// framing state, command completion and music port mask, with result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scf_parse import scf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      beat_vld_i,
  input  cmd_beat_t beat_i,
  output logic      beat_take_o,
  output logic      res_vld_o,
  input  logic      res_rdy_i,
  output res_beat_t res_o
);

  logic        halted_q, halted_d;
  logic [2:0]  left_q, left_d;
  logic [7:0]  op_q, op_d;
  logic [3:0]  port_q, port_d;
  logic [15:0] mask_q, mask_d;
  logic        res_vld_q, res_vld_d;
  res_beat_t   res_q, res_d;

  logic        step_go;
  logic        halt_eff;
  logic [2:0]  left_eff;
  logic [3:0]  len;
  logic [3:0]  port_new;
  logic        has_res;
  logic [7:0]  fin_op;
  logic [3:0]  fin_port;
  logic [15:0] port_bit;
  logic [15:0] mask_new;
  action_e     act;

  assign step_go     = beat_vld_i && (!res_vld_q || res_rdy_i);
  assign beat_take_o = step_go;

  // framing
  always_comb begin
    halted_d = halted_q;
    left_d   = left_q;
    op_d     = op_q;
    port_d   = port_q;
    has_res  = 1'b0;
    fin_op   = op_q;
    fin_port = port_q;
    len      = 4'd0;
    port_new = port_q;
    halt_eff = halted_q && !beat_i.buffer_start;
    left_eff = beat_i.buffer_start ? 3'd0 : left_q;
    if (step_go) begin
      halted_d = halt_eff;
      left_d   = left_eff;
      if (!halt_eff) begin
        if (left_eff == 3'd0) begin
          len = frame_len(beat_i.data_byte);
          if (beat_i.data_byte == OP_END || len == 4'd0) begin
            halted_d = 1'b1;
          end else if (len == 4'd1) begin
            has_res  = 1'b1;
            fin_op   = beat_i.data_byte;
            fin_port = 4'd0;
          end else begin
            op_d   = beat_i.data_byte;
            port_d = 4'd0;
            left_d = 3'(len - 4'd1);
          end
        end else begin
          len = frame_len(op_q);
          if ({1'b0, left_eff} + 4'd1 == len) begin
            port_new = beat_i.data_byte[3:0];
          end
          port_d = port_new;
          left_d = left_eff - 3'd1;
          if (left_eff == 3'd1) begin
            has_res  = 1'b1;
            fin_op   = op_q;
            fin_port = port_new;
          end
        end
      end
    end
  end

  // command effect
  always_comb begin
    port_bit = 16'd1 << fin_port;
    act      = ACT_OTHER;
    mask_new = mask_q;
    case (fin_op)
      OP_BGM_START: begin
        mask_new = mask_q | port_bit;
        act      = ACT_BGM_START;
      end
      OP_BGM_STOP: begin
        mask_new = mask_q & ~port_bit;
        act      = ACT_BGM_STOP;
      end
      OP_MUSIC_SUM: begin
        if (fin_port < MUSIC_PORTS) act = ACT_MUSIC_SUM;
      end
      OP_EFFECT_SUM: begin
        if (fin_port < EFFECT_PORTS) act = ACT_EFFECT_SUM;
      end
      OP_STOP_ALL: act = ACT_STOP_ALL;
      default: act = ACT_OTHER;
    endcase
    mask_d = has_res ? mask_new : mask_q;
    res_d  = '{action: act, cmd_code: fin_op, port_number: fin_port, bgm_mask: mask_new};
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (step_go && has_res) begin
      res_vld_d = 1'b1;
    end else if (res_rdy_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q  <= 1'b0;
      left_q    <= 3'd0;
      op_q      <= 8'd0;
      port_q    <= 4'd0;
      mask_q    <= 16'd0;
      res_vld_q <= 1'b0;
    end else begin
      halted_q  <= halted_d;
      left_q    <= left_d;
      op_q      <= op_d;
      port_q    <= port_d;
      mask_q    <= mask_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  `ASSERT_AT(a_halt_holds, clk_i, rst_ni,
    (step_go && halted_q && !beat_i.buffer_start) |=> halted_q)
  `ASSERT_AT(a_mask_only_on_result, clk_i, rst_ni,
    !(step_go && has_res) |=> $stable(mask_q))
  `ASSERT_NEVER(a_halt_mid_command, clk_i, rst_ni, halted_q && (left_q != 3'd0))
  `ASSERT_AT(a_result_mask_current, clk_i, rst_ni, res_vld_q |-> (res_q.bgm_mask == mask_q))

endmodule

### tb/sv/scf_result_checker.sv
// ----------------------------------------------------------------------------
// scf_result_checker
// watches both channels of the sound command framer, predicts each completed
// command from the accepted byte beats and compares it with the result beats
// ----------------------------------------------------------------------------
module scf_result_checker import scf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  scf_cmd_if   cmd_i,
  scf_res_if   res_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  logic        in_halt;
  logic [2:0]  left_count;
  logic [7:0]  open_opcode;
  logic [3:0]  open_port;
  logic [15:0] port_mask;

  res_beat_t   awaited_results[$];

  function automatic int unsigned command_length(input logic [7:0] op);
    int unsigned n;
    n = 0;
    if (op[7:4] == 4'h0) begin
      n = 4 + op[0] + op[1] + 2 * op[2];
    end else if (op[7:4] == 4'h1) begin
      n = (op == 8'h11) ? 3 : 1;
    end else if (op[7:4] == 4'h2) begin
      if (op >= 8'h22 && op <= 8'h25) n = 3;
      else if (op == 8'h26) n = 4;
      else if (op == 8'h20) n = 5;
      else if (op == 8'h27 || op == 8'h28 || op == 8'h29 || op == 8'h2C || op == 8'h2D) n = 8;
      else n = 2;
    end else if (op[7:4] == 4'h4) begin
      if (op == 8'h41 || op == 8'h42 || (op >= 8'h47 && op <= 8'h4A)) n = 2;
      else if (op == 8'h4B || op == 8'h4D || op == 8'h4E) n = 3;
      else if (op == 8'h45 || op == 8'h4C) n = 4;
      else if (op == 8'h44 || op == 8'h4F) n = 6;
      else n = 1;
    end else if (op[7:4] == 4'h5 || op[7:4] == 4'h6) begin
      n = (op >= 8'h51 && op <= 8'h54) ? 8 : 2;
    end
    return n;
  endfunction

  task automatic apply_command(input logic [7:0] op, input logic [3:0] port);
    res_beat_t done;
    done.action = ACT_OTHER;
    case (op)
      OP_BGM_START: begin
        port_mask   = port_mask | (16'd1 << port);
        done.action = ACT_BGM_START;
      end
      OP_BGM_STOP: begin
        port_mask   = port_mask & ~(16'd1 << port);
        done.action = ACT_BGM_STOP;
      end
      OP_MUSIC_SUM: begin
        if (port < MUSIC_PORTS) done.action = ACT_MUSIC_SUM;
      end
      OP_EFFECT_SUM: begin
        if (port < EFFECT_PORTS) done.action = ACT_EFFECT_SUM;
      end
      OP_STOP_ALL: begin
        done.action = ACT_STOP_ALL;
      end
      default: begin
      end
    endcase
    done.cmd_code    = op;
    done.port_number = port;
    done.bgm_mask    = port_mask;
    left_count       = '0;
    awaited_results  = {awaited_results, done};
  endtask

  task automatic frame_byte(input logic [7:0] b, input logic first);
    int unsigned len;
    if (first) begin
      in_halt    = 1'b0;
      left_count = '0;
    end
    if (in_halt) return;
    if (left_count == 0) begin
      len = command_length(b);
      if (b == OP_END || len == 0) begin
        in_halt = 1'b1;
      end else if (len == 1) begin
        apply_command(b, 4'd0);
      end else begin
        open_opcode = b;
        open_port   = '0;
        left_count  = 3'(len - 1);
      end
      return;
    end
    // port nibble rides in the byte right after the opcode
    if (left_count + 1 == command_length(open_opcode)) open_port = b[3:0];
    left_count = left_count - 3'd1;
    if (left_count == 0) apply_command(open_opcode, open_port);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count_o++;
    end
  endfunction

  task automatic check_result();
    res_beat_t want;
    if (awaited_results.size() == 0) begin
      $error("cmd_code: expected no beat, got %0h", res_i.cmd_code);
      mismatch_count_o++;
    end else begin
      want = awaited_results.pop_front();
      compare_field("action", 16'(want.action), 16'(res_i.action));
      compare_field("cmd_code", 16'(want.cmd_code), 16'(res_i.cmd_code));
      compare_field("port_number", 16'(want.port_number), 16'(res_i.port_number));
      compare_field("bgm_mask", want.bgm_mask, res_i.bgm_mask);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_halt     = 1'b0;
      left_count  = '0;
      open_opcode = '0;
      open_port   = '0;
      port_mask   = '0;
      awaited_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (cmd_i.valid && cmd_i.ready) frame_byte(cmd_i.data_byte, cmd_i.buffer_start);
      pending_o = awaited_results.size();
    end
  end

endmodule

### tb/sv/sound_command_stream_framer_test.sv
// ----------------------------------------------------------------------------
// sound_command_stream_framer_test
// drives command buffers into the framer, directed corner cases first and then
// random buffers of mostly well-formed commands with truncations, end markers
// and undefined opcodes, under bursty input and a stalling result receiver;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module sound_command_stream_framer_test;
  import scf_pkg::*;

  localparam logic [7:0] OP_PLAIN     = 8'h40;
  localparam logic [7:0] OP_UNDEFINED = 8'h70;
  localparam int         LIVE_TARGET  = 1775;

  logic      clk_i;
  logic      rst_ni;
  int        mismatch_count;
  int        pending;
  int        live_bytes;
  cmd_beat_t stream_q[$];

  scf_cmd_if cmd_bus ();
  scf_res_if res_bus ();

  sound_command_stream_framer u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  scf_result_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_bus),
    .res_i           (res_bus),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("sound_command_stream_framer_test failed");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] b, input logic first, input bit live);
    cmd_beat_t beat;
    beat.data_byte    = b;
    beat.buffer_start = first;
    stream_q = {stream_q, beat};
    if (live) live_bytes++;
  endfunction

  function automatic void emit_command(input logic [7:0] op, input logic [7:0] port_byte,
                                       input logic first, input int unsigned nbytes);
    push_byte(op, first, 1'b1);
    for (int i = 1; i < nbytes; i++) begin
      push_byte((i == 1) ? port_byte : 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        case ($urandom_range(0, 4))
          0:       op = OP_STOP_ALL;
          1:       op = OP_BGM_START;
          2:       op = OP_BGM_STOP;
          3:       op = OP_MUSIC_SUM;
          default: op = OP_EFFECT_SUM;
        endcase
      end
      9: op = 8'($urandom_range(0, 255));
      default: begin
        do op = 8'($urandom_range(0, 255)); while (frame_len(op) == 0);
      end
    endcase
    return op;
  endfunction

  function automatic void add_buffer();
    int unsigned cmds;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  op;
    logic [7:0]  port_byte;
    logic        first;
    cmds  = $urandom_range(1, 8);
    first = 1'b1;
    for (int c = 0; c < cmds; c++) begin
      op  = pick_opcode();
      len = frame_len(op);
      if (len == 0) begin
        push_byte(op, first, 1'b1);
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        return;
      end
      port_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1)) port_byte[3:0] = 4'($urandom_range(0, 6));
      // occasionally cut the command short so the next buffer drops it
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len) : len;
      emit_command(op, port_byte, first, cut);
      first = 1'b0;
      if (cut < len) return;
    end
    if ($urandom_range(0, 3) == 0) begin
      push_byte(OP_END, first, 1'b1);
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endfunction

  task automatic send_beat(input cmd_beat_t beat);
    cmd_bus.valid        <= 1'b1;
    cmd_bus.data_byte    <= beat.data_byte;
    cmd_bus.buffer_start <= beat.buffer_start;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // result receiver: always ready, coin flip, or mostly stalled
  initial begin
    int stall_mode;
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk_i);
        case (stall_mode)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= 1'($urandom_range(0, 1));
          default: res_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int idx;
    int burst;
    int gap;
    rst_ni               <= 1'b0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.data_byte    <= '0;
    cmd_bus.buffer_start <= 1'b0;
    live_bytes = 0;

    // directed corner cases
    emit_command(OP_STOP_ALL, 8'h00, 1'b1, 1);
    emit_command(OP_BGM_START, 8'hFF, 1'b0, frame_len(OP_BGM_START));
    emit_command(OP_BGM_STOP, 8'h0F, 1'b0, frame_len(OP_BGM_STOP));
    emit_command(OP_PLAIN, 8'h00, 1'b0, 1);
    emit_command(OP_MUSIC_SUM, 8'hF3, 1'b0, frame_len(OP_MUSIC_SUM));
    push_byte(OP_END, 1'b0, 1'b1);
    push_byte(OP_STOP_ALL, 1'b0, 1'b0);
    emit_command(OP_EFFECT_SUM, 8'h04, 1'b1, 3);
    emit_command(OP_STOP_ALL, 8'h00, 1'b1, 1);
    push_byte(OP_UNDEFINED, 1'b0, 1'b1);

    while (live_bytes < LIVE_TARGET) add_buffer();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idx = 0;
    while (idx < stream_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stream_q.size()) begin
        send_beat(stream_q[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    cmd_bus.valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("sound_command_stream_framer_test passed");
    end else begin
      $display("sound_command_stream_framer_test failed");
    end
    $finish;
  end

endmodule
